// ===== rtl/met_pkg.sv =====
package met_pkg;

  // Coordinate format and count widths
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 28;
  localparam int COUNT_WIDTH = 24;

  // Register and port widths fixed by the register map
  localparam int CFG_DATA_WIDTH  = 32;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int ITER_WIDTH      = 24;
  localparam int COLOR_OUT_WIDTH = 24;
  localparam int PALETTE_WIDTH   = 9;
  localparam int MASK_WIDTH      = 8;

  // Derived widths
  localparam int COLOR_WIDTH    = (COUNT_WIDTH > COLOR_OUT_WIDTH) ? COUNT_WIDTH : COLOR_OUT_WIDTH;
  localparam int FOLD_CNT_WIDTH = $clog2(COLOR_WIDTH);
  localparam int PROD_WIDTH     = 2 * COORD_WIDTH;
  localparam int QUOT_WIDTH     = PROD_WIDTH - FRAC_BITS;

  // Coordinate range limits, as raw two's complement bit patterns
  localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // Escape threshold 4.0, or the largest positive value if 4.0 does not fit
  localparam logic [COORD_WIDTH-1:0] ESC_THRESH =
    (FRAC_BITS + 2 <= COORD_WIDTH - 2) ? (COORD_WIDTH'(4) << FRAC_BITS) : COORD_MAX;

  // Palettes smaller than this fold by masking
  localparam logic [PALETTE_WIDTH-1:0] SMALL_PALETTE = PALETTE_WIDTH'(16);

  // Register reset values
  localparam logic [ITER_WIDTH-1:0]      RST_MAX_ITER     = ITER_WIDTH'(150);
  localparam logic [COLOR_OUT_WIDTH-1:0] RST_INSIDE_COLOR = COLOR_OUT_WIDTH'(1);
  localparam logic [PALETTE_WIDTH-1:0]   RST_PALETTE_SIZE = PALETTE_WIDTH'(256);
  localparam logic [MASK_WIDTH-1:0]      RST_FOLD_MASK    = MASK_WIDTH'(255);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_START_REAL = 3'd0,
    REG_START_IMAG = 3'd1,
    REG_MAX_ITER   = 3'd2,
    REG_INSIDE     = 3'd3,
    REG_PALETTE    = 3'd4,
    REG_FOLD_MASK  = 3'd5
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_NORM,
    ST_SUM,
    ST_CHECK,
    ST_FOLD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [CFG_DATA_WIDTH-1:0]  start_real;
    logic [CFG_DATA_WIDTH-1:0]  start_imag;
    logic [ITER_WIDTH-1:0]      max_iterations;
    logic [COLOR_OUT_WIDTH-1:0] inside_color;
    logic [PALETTE_WIDTH-1:0]   palette_size;
    logic [MASK_WIDTH-1:0]      fold_mask;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic norm;
    logic sum;
    logic fold_start;
    logic fold_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic limit_zero;
    logic sum_done;
    logic need_mod;
  } status_t;

endpackage

// ===== rtl/met_ctrl.sv =====
module met_ctrl
  import met_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t                    state;
  state_t                    state_next;
  logic [FOLD_CNT_WIDTH-1:0] fold_cnt;
  logic                      out_free;

  // Output register can take a new beat when empty or being drained
  assign out_free = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.limit_zero ? ST_CHECK : ST_MUL;
        end
      end
      ST_MUL:   state_next = ST_NORM;
      ST_NORM:  state_next = ST_SUM;
      ST_SUM:   state_next = status.sum_done ? ST_CHECK : ST_MUL;
      ST_CHECK: state_next = status.need_mod ? ST_FOLD : ST_OUT;
      ST_FOLD: begin
        if (fold_cnt == '0) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_MUL:   cmd.mul = 1'b1;
      ST_NORM:  cmd.norm = 1'b1;
      ST_SUM:   cmd.sum = 1'b1;
      ST_CHECK: cmd.fold_start = status.need_mod;
      ST_FOLD:  cmd.fold_step = 1'b1;
      ST_OUT:   cmd.out_load = out_free;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      fold_cnt  <= '0;
    end else begin
      state <= state_next;
      // Hold the result beat until the receiver takes it
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      // Count remainder steps
      if (cmd.fold_start) begin
        fold_cnt <= FOLD_CNT_WIDTH'(COLOR_WIDTH - 1);
      end else if (cmd.fold_step) begin
        fold_cnt <= fold_cnt - 1'b1;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again before the point finished");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.mul, cmd.norm, cmd.sum, cmd.fold_start, cmd.fold_step,
              cmd.out_load}))
    else $error("more than one datapath command");

  a_fold_length: assert property (@(posedge clk) disable iff (rst)
    cmd.fold_start |=> (fold_cnt == FOLD_CNT_WIDTH'(COLOR_WIDTH - 1)) && (state == ST_FOLD))
    else $error("remainder sequence not started correctly");

endmodule

// ===== rtl/met_dp.sv =====
module met_dp
  import met_pkg::*;
(
  input  logic                       clk,
  input  cfg_t                       cfg,
  input  cmd_t                       cmd,
  input  logic [COORD_WIDTH-1:0]     c_real,
  input  logic [COORD_WIDTH-1:0]     c_imag,
  output status_t                    status,
  output logic [COLOR_OUT_WIDTH-1:0] pixel_color
);

  // Exact product magnitude, truncated, saturated and signed again; {ovf, value}
  function automatic logic [COORD_WIDTH:0] norm_prod(input logic [PROD_WIDTH-1:0] prod,
                                                     input logic neg);
    logic [QUOT_WIDTH-1:0]  q;
    logic [QUOT_WIDTH-1:0]  lim;
    logic                   ovf;
    logic [COORD_WIDTH-1:0] mag;
    q   = QUOT_WIDTH'(prod >> FRAC_BITS);
    lim = QUOT_WIDTH'(COORD_MAX) + QUOT_WIDTH'(neg);
    ovf = (q > lim);
    mag = ovf ? lim[COORD_WIDTH-1:0] : q[COORD_WIDTH-1:0];
    return {ovf, (neg ? (COORD_WIDTH'(0) - mag) : mag)};
  endfunction

  // Saturating signed add; {ovf, value}
  function automatic logic [COORD_WIDTH:0] sat_add(input logic [COORD_WIDTH-1:0] a,
                                                   input logic [COORD_WIDTH-1:0] b);
    logic [COORD_WIDTH:0]   s;
    logic                   ovf;
    logic [COORD_WIDTH-1:0] r;
    s   = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
    ovf = s[COORD_WIDTH] ^ s[COORD_WIDTH-1];
    r   = ovf ? (s[COORD_WIDTH] ? COORD_MIN : COORD_MAX) : s[COORD_WIDTH-1:0];
    return {ovf, r};
  endfunction

  logic [COORD_WIDTH-1:0] cr, ci, zr, zi;
  logic [COUNT_WIDTH-1:0] count;
  logic                   ovf_acc;
  logic [COUNT_WIDTH-1:0] limit;
  logic [COUNT_WIDTH-1:0] count_inc;

  logic [COORD_WIDTH-1:0] abs_r, abs_i;
  logic [PROD_WIDTH-1:0]  prod_rr, prod_ii, prod_ri;
  logic                   neg_ri;

  logic [COORD_WIDTH-1:0] p_rr, p_ii, p_ri;
  logic                   o_rr, o_ii, o_ri;
  logic [COORD_WIDTH:0]   n_rr, n_ii, n_ri;

  logic [COORD_WIDTH-1:0] t1, t2, nr, ni, mag;
  logic                   o_t1, o_t2, o_nr, o_ni, o_mag;
  logic                   escaped_prev;
  logic                   last_iter;
  logic                   iter_ovf;

  logic [COLOR_WIDTH-1:0] color;
  logic [COLOR_WIDTH-1:0] div_sh;
  logic [MASK_WIDTH-1:0]  rem;
  logic [MASK_WIDTH:0]    rem_sh;
  logic                   rem_ge;
  logic                   big, small_pal, mask_zero;
  logic [COLOR_WIDTH-1:0] fold_val;

  assign limit     = COUNT_WIDTH'(cfg.max_iterations);
  assign count_inc = count + 1'b1;

  // Product operands as magnitudes
  assign abs_r = zr[COORD_WIDTH-1] ? (COORD_WIDTH'(0) - zr) : zr;
  assign abs_i = zi[COORD_WIDTH-1] ? (COORD_WIDTH'(0) - zi) : zi;

  // Scale and saturate registered products
  assign n_rr = norm_prod(prod_rr, 1'b0);
  assign n_ii = norm_prod(prod_ii, 1'b0);
  assign n_ri = norm_prod(prod_ri, neg_ri);

  // New z, and magnitude of the z that fed the current products
  assign {o_t1, t1}   = sat_add(p_rr, COORD_WIDTH'(0) - p_ii);
  assign {o_nr, nr}   = sat_add(t1, cr);
  assign {o_t2, t2}   = sat_add(p_ri, p_ri);
  assign {o_ni, ni}   = sat_add(t2, ci);
  assign {o_mag, mag} = sat_add(p_rr, p_ii);

  assign iter_ovf     = o_rr | o_ii | o_ri | o_t1 | o_nr | o_t2 | o_ni;
  assign escaped_prev = (count != '0) &&
                        (ovf_acc || o_rr || o_ii || o_mag ||
                         ($signed(mag) >= $signed(ESC_THRESH)));
  assign last_iter    = (count_inc == limit);

  // Palette folding
  assign big       = (color >= COLOR_WIDTH'(cfg.palette_size));
  assign small_pal = (cfg.palette_size < SMALL_PALETTE);
  assign mask_zero = (cfg.fold_mask == '0);
  assign rem_sh    = {rem, div_sh[COLOR_WIDTH-1]};
  assign rem_ge    = (rem_sh >= {1'b0, cfg.fold_mask});

  always_comb begin
    fold_val = color;
    if (big) begin
      if (small_pal) begin
        fold_val = color & COLOR_WIDTH'(cfg.fold_mask);
      end else if (!mask_zero) begin
        fold_val = COLOR_WIDTH'(rem) + 1'b1;
      end
    end
  end

  assign status.limit_zero = (limit == '0);
  assign status.sum_done   = escaped_prev || last_iter;
  assign status.need_mod   = big && !small_pal && !mask_zero;

  always_ff @(posedge clk) begin
    // Start a point
    if (cmd.load) begin
      cr      <= c_real;
      ci      <= c_imag;
      zr      <= COORD_WIDTH'(cfg.start_real);
      zi      <= COORD_WIDTH'(cfg.start_imag);
      count   <= '0;
      ovf_acc <= 1'b0;
      color   <= COLOR_WIDTH'(cfg.inside_color);
    end
    // Multiply magnitudes
    if (cmd.mul) begin
      prod_rr <= PROD_WIDTH'(abs_r) * PROD_WIDTH'(abs_r);
      prod_ii <= PROD_WIDTH'(abs_i) * PROD_WIDTH'(abs_i);
      prod_ri <= PROD_WIDTH'(abs_r) * PROD_WIDTH'(abs_i);
      neg_ri  <= zr[COORD_WIDTH-1] ^ zi[COORD_WIDTH-1];
    end
    // Scale products
    if (cmd.norm) begin
      {o_rr, p_rr} <= n_rr;
      {o_ii, p_ii} <= n_ii;
      {o_ri, p_ri} <= n_ri;
    end
    // Escape check of previous iteration, else advance one iteration
    if (cmd.sum) begin
      if (escaped_prev) begin
        color <= COLOR_WIDTH'(count);
      end else begin
        zr      <= nr;
        zi      <= ni;
        ovf_acc <= iter_ovf;
        count   <= count_inc;
        if (last_iter) begin
          color <= COLOR_WIDTH'(cfg.inside_color);
        end
      end
    end
    // Bit-serial remainder of (color - 1) by the fold mask
    if (cmd.fold_start) begin
      div_sh <= color - 1'b1;
      rem    <= '0;
    end else if (cmd.fold_step) begin
      div_sh <= div_sh << 1;
      rem    <= rem_ge ? MASK_WIDTH'(rem_sh - {1'b0, cfg.fold_mask}) : MASK_WIDTH'(rem_sh);
    end
    // Result beat
    if (cmd.out_load) begin
      pixel_color <= COLOR_OUT_WIDTH'(fold_val);
    end
  end

endmodule

// ===== rtl/mandelbrot_escape_time.sv =====
// Mandelbrot escape-time evaluator, one complex point per input beat.
// Input channel: c_real, c_imag (Q4.28 signed) with in_valid / in_stall;
// a beat moves when in_valid is high and in_stall is low. in_stall is low
// only while the block is idle, so one point is worked on at a time.
// Output channel: pixel_color with out_valid / out_stall; the result sits in
// an output register until taken, and the next point is accepted meanwhile.
// Configuration: cfg_write with cfg_index (0 start_real, 1 start_imag,
// 2 max_iterations, 3 inside_color, 4 palette_size, 5 fold_mask) and
// cfg_data; other indexes are ignored. Write only while idle.
// Timing: each iteration runs through one multiply, scale and sum
// step sequence (three 32x32 multipliers shared by nothing else). After
// the last iteration a point passes a check state, then an output state
// that loads the result register and sets out_valid. Folding by a modulus
// (palette of 16 or more colors) adds a fold state for the bit-serial
// remainder. A zero limit skips the iterations and gives the inside color.
// The next point can be accepted in the same cycle that out_valid rises.
// Reset clears the controller and the output valid and restores register
// defaults (limit 150, inside color 1, 256 colors, mask 255).
// A stalled receiver holds the result; a finished point then waits in the
// last state until the output register frees up.
module mandelbrot_escape_time
  import met_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [COORD_WIDTH-1:0]     c_real,
  input  logic [COORD_WIDTH-1:0]     c_imag,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [COLOR_OUT_WIDTH-1:0] pixel_color
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_real     <= '0;
      cfg.start_imag     <= '0;
      cfg.max_iterations <= RST_MAX_ITER;
      cfg.inside_color   <= RST_INSIDE_COLOR;
      cfg.palette_size   <= RST_PALETTE_SIZE;
      cfg.fold_mask      <= RST_FOLD_MASK;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_START_REAL: cfg.start_real     <= cfg_data;
        REG_START_IMAG: cfg.start_imag     <= cfg_data;
        REG_MAX_ITER:   cfg.max_iterations <= cfg_data[ITER_WIDTH-1:0];
        REG_INSIDE:     cfg.inside_color   <= cfg_data[COLOR_OUT_WIDTH-1:0];
        REG_PALETTE:    cfg.palette_size   <= cfg_data[PALETTE_WIDTH-1:0];
        REG_FOLD_MASK:  cfg.fold_mask      <= cfg_data[MASK_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  met_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  met_dp u_dp (
    .clk         (clk),
    .cfg         (cfg),
    .cmd         (cmd),
    .c_real      (c_real),
    .c_imag      (c_imag),
    .status      (status),
    .pixel_color (pixel_color)
  );

endmodule

// ===== bench/escape_color_checker.sv =====
`timescale 1ns / 100ps

// Watch the register port and both channels, predict each pixel color and
// compare it with what comes out, oldest first.
module escape_color_checker
  import met_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [COORD_WIDTH-1:0]     c_real,
  input  logic [COORD_WIDTH-1:0]     c_imag,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [COLOR_OUT_WIDTH-1:0] pixel_color,
  output int                         mismatches,
  output int                         awaiting,
  output int                         pixels_checked,
  output int                         inside_pixels,
  output int                         saturated_pixels
);

  localparam longint COORD_HI     = (longint'(1) << (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_LO     = -COORD_HI - 1;
  localparam longint ESCAPE_LEVEL = longint'(ESC_THRESH);

  typedef struct {
    logic [COORD_WIDTH-1:0]     re;
    logic [COORD_WIDTH-1:0]     im;
    logic [COLOR_OUT_WIDTH-1:0] color;
  } pixel_t;

  cfg_t   settings;
  pixel_t expected_pixels[$];

  // Add with saturation to the coordinate range
  function automatic longint clamp_sum(input longint a, input longint b, inout bit ovf);
    longint s;
    s = a + b;
    if (s > COORD_HI) begin
      ovf = 1'b1;
      s   = COORD_HI;
    end else if (s < COORD_LO) begin
      ovf = 1'b1;
      s   = COORD_LO;
    end
    return s;
  endfunction

  // Multiply, truncate the magnitude toward zero, then saturate
  function automatic longint scaled_product(input longint a, input longint b, inout bit ovf);
    bit              neg;
    longint          ma;
    longint          mb;
    longint unsigned mag;
    longint unsigned lim;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    mag = ma * mb;
    mag = mag >> FRAC_BITS;
    lim = COORD_HI + (neg ? 1 : 0);
    if (mag > lim) begin
      ovf = 1'b1;
      mag = lim;
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  // Iterate z = z*z + c from the start value, then fold into the palette
  function automatic logic [COLOR_OUT_WIDTH-1:0] predict_color(
    input  logic [COORD_WIDTH-1:0] re,
    input  logic [COORD_WIDTH-1:0] im,
    output bit                     reached_limit,
    output bit                     saturated
  );
    longint          cr, ci, zr, zi, rr, ii, ri, nr, ni, t, mag;
    longint unsigned count, limit, color;
    bit              escaped, ovf;
    cr        = longint'($signed(re));
    ci        = longint'($signed(im));
    zr        = longint'($signed(settings.start_real));
    zi        = longint'($signed(settings.start_imag));
    limit     = settings.max_iterations;
    count     = 0;
    escaped   = 1'b0;
    saturated = 1'b0;
    while (!escaped && count < limit) begin
      ovf = 1'b0;
      rr  = scaled_product(zr, zr, ovf);
      ii  = scaled_product(zi, zi, ovf);
      ri  = scaled_product(zr, zi, ovf);
      t   = clamp_sum(rr, -ii, ovf);
      nr  = clamp_sum(t, cr, ovf);
      t   = clamp_sum(ri, ri, ovf);
      ni  = clamp_sum(t, ci, ovf);
      rr  = scaled_product(nr, nr, ovf);
      ii  = scaled_product(ni, ni, ovf);
      mag = clamp_sum(rr, ii, ovf);
      count++;
      zr = nr;
      zi = ni;
      if (ovf || mag >= ESCAPE_LEVEL) begin
        escaped   = 1'b1;
        saturated = ovf;
      end
    end
    reached_limit = (count >= limit);
    color = reached_limit ? longint'(settings.inside_color) : count;
    // Fold colors past the end of the palette
    if (color >= settings.palette_size) begin
      if (settings.palette_size < SMALL_PALETTE)
        color = color & settings.fold_mask;
      else if (settings.fold_mask != '0)
        color = ((color - 1) % settings.fold_mask) + 1;
    end
    return color[COLOR_OUT_WIDTH-1:0];
  endfunction

  always @(posedge clk) begin : watch
    pixel_t                     want;
    logic [COLOR_OUT_WIDTH-1:0] color;
    bit                         at_limit;
    bit                         sat;
    if (rst) begin
      settings.start_real     = '0;
      settings.start_imag     = '0;
      settings.max_iterations = RST_MAX_ITER;
      settings.inside_color   = RST_INSIDE_COLOR;
      settings.palette_size   = RST_PALETTE_SIZE;
      settings.fold_mask      = RST_FOLD_MASK;
      expected_pixels.delete();
      awaiting <= 0;
    end else begin
      // Compare each result beat with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          $display("%0t: pixel_color %h arrived with no point outstanding",
                   $time, pixel_color);
        end else begin
          want = expected_pixels.pop_front();
          pixels_checked++;
          if (pixel_color !== want.color) begin
            mismatches++;
            $display("%0t: pixel_color for c = (%h, %h): expected %h, got %h",
                     $time, want.re, want.im, want.color, pixel_color);
          end
        end
      end
      // Mirror register writes; unmapped indexes are dropped
      if (cfg_write) begin
        case (cfg_index)
          REG_START_REAL: settings.start_real     = cfg_data;
          REG_START_IMAG: settings.start_imag     = cfg_data;
          REG_MAX_ITER:   settings.max_iterations = cfg_data[ITER_WIDTH-1:0];
          REG_INSIDE:     settings.inside_color   = cfg_data[COLOR_OUT_WIDTH-1:0];
          REG_PALETTE:    settings.palette_size   = cfg_data[PALETTE_WIDTH-1:0];
          REG_FOLD_MASK:  settings.fold_mask      = cfg_data[MASK_WIDTH-1:0];
          default: ;
        endcase
      end
      // Predict the color of each accepted point beat
      if (in_valid && !in_stall) begin
        color = predict_color(c_real, c_imag, at_limit, sat);
        if (at_limit)
          inside_pixels++;
        else if (sat)
          saturated_pixels++;
        want.re    = c_real;
        want.im    = c_imag;
        want.color = color;
        expected_pixels.push_back(want);
      end
      awaiting <= expected_pixels.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench
  import met_pkg::*;
();

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int IDLE_PERCENT    = 9;
  localparam int HOLD_CYCLES     = 1500;
  localparam int TAIL_CYCLES     = 1000;
  localparam int MAX_CYCLES      = 5_000_000;

  localparam logic [CFG_INDEX_WIDTH-1:0] UNMAPPED_LO = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] UNMAPPED_HI = 3'd7;

  // Q4.28 constants for the directed points
  localparam logic [COORD_WIDTH-1:0] Q_ONE         = 32'h1000_0000;
  localparam logic [COORD_WIDTH-1:0] Q_NEG_ONE     = 32'hF000_0000;
  localparam logic [COORD_WIDTH-1:0] Q_NEG_TWO     = 32'hE000_0000;
  localparam logic [COORD_WIDTH-1:0] Q_HALF        = 32'h0800_0000;
  localparam logic [COORD_WIDTH-1:0] Q_QUARTER     = 32'h0400_0000;
  localparam logic [COORD_WIDTH-1:0] Q_SIXTEENTH   = 32'h0100_0000;
  localparam logic [COORD_WIDTH-1:0] Q_NEG_3_4     = 32'hF400_0000;
  localparam logic [COORD_WIDTH-1:0] Q_POINT_THREE = 32'h04CC_CCCD;

  typedef enum {PT_ANY, PT_NEAR_SET, PT_OUTSIDE} point_kind_t;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;
  logic                       in_valid  = 1'b0;
  logic [COORD_WIDTH-1:0]     c_real    = '0;
  logic [COORD_WIDTH-1:0]     c_imag    = '0;
  logic                       out_stall = 1'b0;
  logic                       in_stall;
  logic                       out_valid;
  logic [COLOR_OUT_WIDTH-1:0] pixel_color;

  int mismatches;
  int awaiting;
  int pixels_checked;
  int inside_pixels;
  int saturated_pixels;
  int points_sent   = 0;
  int settings_used = 0;
  int cycle_count   = 0;
  int hold_req      = 0;
  int hold_taken    = 0;
  int hold_left     = 0;
  bit calm          = 1'b0;

  always #4 clk = ~clk;

  mandelbrot_escape_time DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .c_real     (c_real),
    .c_imag     (c_imag),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_color(pixel_color)
  );

  escape_color_checker color_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .c_real          (c_real),
    .c_imag          (c_imag),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .pixel_color     (pixel_color),
    .mismatches      (mismatches),
    .awaiting        (awaiting),
    .pixels_checked  (pixels_checked),
    .inside_pixels   (inside_pixels),
    .saturated_pixels(saturated_pixels)
  );

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("Timed out after %0d cycles with %0d colors outstanding",
               cycle_count, awaiting);
      $display("** mandelbrot_escape_time: FAILED **");
      $finish;
    end
  end

  // Stall the result side: random gaps, calm stretches and one long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_taken != hold_req) begin
      hold_taken = hold_req;
      hold_left  = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Small start offset within +-0.5
  function automatic logic [COORD_WIDTH-1:0] near_origin();
    return $urandom_range(1 << 28) - (1 << 27);
  endfunction

  // Draw a point: anywhere, around the set, or certain to escape at once
  function automatic logic [2*COORD_WIDTH-1:0] pick_point(input point_kind_t kind);
    logic [COORD_WIDTH-1:0] re, im, span;
    case (kind)
      PT_NEAR_SET: begin
        re = $urandom_range(12 << 26) - (9 << 26);
        im = $urandom_range(12 << 26) - (6 << 26);
      end
      PT_OUTSIDE: begin
        span = (2 << 28) + 1 + $urandom_range((6 << 28) - 2);
        re   = $urandom_range(1) ? -span : span;
        im   = $urandom;
      end
      default: begin
        re = $urandom;
        im = $urandom;
      end
    endcase
    return {re, im};
  endfunction

  // Offer one point beat, hold it until taken, then maybe idle
  task automatic send_point(input logic [COORD_WIDTH-1:0] re, input logic [COORD_WIDTH-1:0] im);
    int gap;
    in_valid <= 1'b1;
    c_real   <= re;
    c_imag   <= im;
    do @(posedge clk); while (in_stall);
    points_sent++;
    gap = 0;
    while (!calm && $urandom_range(99) < IDLE_PERCENT)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted color has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write all six registers back to back, after one write to an unmapped index
  task automatic configure(
    input logic [COORD_WIDTH-1:0]     sr,
    input logic [COORD_WIDTH-1:0]     si,
    input logic [ITER_WIDTH-1:0]      mi,
    input logic [COLOR_OUT_WIDTH-1:0] ic,
    input logic [PALETTE_WIDTH-1:0]   ps,
    input logic [MASK_WIDTH-1:0]      fm
  );
    logic [CFG_INDEX_WIDTH-1:0] idx [7];
    logic [CFG_DATA_WIDTH-1:0]  val [7];
    idx[0] = $urandom_range(1) ? UNMAPPED_HI : UNMAPPED_LO;
    val[0] = $urandom;
    idx[1] = REG_START_REAL;
    val[1] = sr;
    idx[2] = REG_START_IMAG;
    val[2] = si;
    idx[3] = REG_MAX_ITER;
    val[3] = CFG_DATA_WIDTH'(mi);
    idx[4] = REG_INSIDE;
    val[4] = CFG_DATA_WIDTH'(ic);
    idx[5] = REG_PALETTE;
    val[5] = CFG_DATA_WIDTH'(ps);
    idx[6] = REG_FOLD_MASK;
    val[6] = CFG_DATA_WIDTH'(fm);
    for (int k = 0; k < 7; k++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [2*COORD_WIDTH-1:0] pt;
    point_kind_t              kind;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: origin, corners, exact threshold, slow and periodic points
    send_point('0, '0);
    send_point(COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MIN);
    send_point(COORD_MIN, COORD_MAX);
    send_point(COORD_MAX, COORD_MIN);
    send_point(Q_NEG_TWO, '0);
    send_point(Q_QUARTER, '0);
    send_point(Q_NEG_3_4, Q_SIXTEENTH);
    send_point(Q_HALF, '0);
    send_point('0, Q_ONE);
    drain();

    // Zero limit: inside color straight away, folded by modulus
    configure('0, '0, 24'd0, 24'd300, 9'd256, 8'd255);
    send_point('0, '0);
    send_point(COORD_MAX, COORD_MIN);
    drain();

    // Saturating start value, small palette masking
    configure(COORD_MIN, COORD_MAX, 24'd5, 24'hFFFFFF, 9'd15, 8'hA5);
    send_point('0, '0);
    send_point(Q_ONE, Q_NEG_ONE);
    drain();

    // Two-color palette: fold the inside color and a slow escape by mask
    configure('0, '0, 24'd40, 24'hFFFFFF, 9'd2, 8'h03);
    send_point('0, '0);
    send_point(Q_POINT_THREE, '0);
    send_point(COORD_MAX, '0);
    drain();

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: configure('0, '0, RST_MAX_ITER, RST_INSIDE_COLOR, RST_PALETTE_SIZE, RST_FOLD_MASK);
        1: configure('0, '0, 24'hFFFFFF, 24'hFFFFFF, 9'd256, 8'd0);
        2: configure(near_origin(), near_origin(), ITER_WIDTH'($urandom_range(48, 16)),
                     24'd0, 9'd2, MASK_WIDTH'($urandom));
        3: configure('0, '0, ITER_WIDTH'($urandom_range(60, 20)),
                     COLOR_OUT_WIDTH'($urandom), 9'd16, 8'd1);
        4: configure($urandom, $urandom, 24'd30, COLOR_OUT_WIDTH'($urandom), 9'd15,
                     MASK_WIDTH'($urandom));
        5: configure('0, '0, 24'd255, COLOR_OUT_WIDTH'($urandom),
                     PALETTE_WIDTH'($urandom_range(256, 16)),
                     MASK_WIDTH'($urandom_range(255, 1)));
        6: configure(near_origin(), near_origin(), 24'd1, COLOR_OUT_WIDTH'($urandom),
                     9'd256, 8'd0);
        default: configure('0, '0, ITER_WIDTH'($urandom_range(100, 2)),
                           COLOR_OUT_WIDTH'($urandom),
                           PALETTE_WIDTH'($urandom_range(256, 2)),
                           MASK_WIDTH'($urandom_range(255, 0)));
      endcase
      calm = (p == 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Hold off the result side while points keep coming
        if (p == 2 && n == 20)
          hold_req++;
        if (p == 1)
          kind = PT_OUTSIDE;
        else
          kind = ($urandom_range(99) < 15) ? PT_ANY : PT_NEAR_SET;
        pt = pick_point(kind);
        send_point(pt[2*COORD_WIDTH-1:COORD_WIDTH], pt[COORD_WIDTH-1:0]);
      end
      calm = 1'b0;
      drain();
    end

    // Let any stray beat show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d points under %0d register settings; checked %0d colors", points_sent,
             settings_used, pixels_checked);
    $display("  %0d hit the iteration limit, %0d escaped by saturation, %0d mismatches",
             inside_pixels, saturated_pixels, mismatches);
    if (mismatches == 0 && awaiting == 0) begin
      $display("** mandelbrot_escape_time: PASSED **");
    end else begin
      $display("** mandelbrot_escape_time: FAILED **");
    end
    $finish;
  end

endmodule
